>>> hdl/efqc_pkg.sv
// package for the elevator floor queue controller
// command codes, sizes, reset values and the controller-to-datapath command struct
package efqc_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int FLOOR_W         = 6;
   localparam int SLOT_W          = 5;
   localparam int CMD_W           = 4;
   localparam int DIR_W           = 2;
   localparam int CMP_W           = 7;

   localparam logic [FLOOR_W-1:0] TOP_FLOOR_RST = 6'd20;

   localparam logic [CMD_W-1:0] CMD_TICK   = 4'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 4'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT = 4'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 4'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 4'd4;
   localparam logic [CMD_W-1:0] CMD_ALARM  = 4'd5;
   localparam logic [CMD_W-1:0] CMD_SETFL  = 4'd6;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 4'd7;
   localparam logic [CMD_W-1:0] CMD_RDSLOT = 4'd8;

   localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
   localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

   localparam logic [1:0] CSR_ADDR_TOP_FLOOR = 2'd0;

   typedef struct packed {
      logic load;
      logic match;
      logic encode;
      logic apply;
   } efqc_cmd_type;

endpackage

>>> hdl/efqc_csr.sv
// configuration register block: top_floor behind an apb-style port
// depends on efqc_pkg
module efqc_csr
   import efqc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output logic [FLOOR_W-1:0] top_floor
);

   logic [FLOOR_W-1:0] top_floor_ff;
   logic [FLOOR_W-1:0] top_floor_in;
   logic               sel_top;

   assign sel_top    = (csr_paddr[2] == CSR_ADDR_TOP_FLOOR[0]);
   assign csr_pready = 1'b1;

   always_comb begin
      top_floor_in = top_floor_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_top) begin
         top_floor_in = csr_pwdata[FLOOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_floor_ff <= TOP_FLOOR_RST;
      end else begin
         top_floor_ff <= top_floor_in;
      end
   end

   assign csr_prdata = sel_top ? {{(32-FLOOR_W){1'b0}}, top_floor_ff} : 32'd0;
   assign top_floor  = top_floor_ff;

endmodule

>>> hdl/efqc_ctrl.sv
// controller state machine: accept, match, encode, apply, result handoff
// depends on efqc_pkg
module efqc_ctrl
   import efqc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output efqc_cmd_type cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_MATCH  = 2'd1;
   localparam logic [1:0] S_ENCODE = 2'd2;
   localparam logic [1:0] S_APPLY  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.match  = 1'b0;
      cmd.encode = 1'b0;
      cmd.apply  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            cmd.match = 1'b1;
            state_in  = S_ENCODE;
         end
         S_ENCODE: begin
            cmd.encode = 1'b1;
            state_in   = S_APPLY;
         end
         S_APPLY: begin
            if (out_free) begin
               cmd.apply = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.apply) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_apply_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while stalled");

   a_apply_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> rsp_valid_ff)
      else $error("applied command produced no result");

   a_no_accept_in_flight: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("input accepted while a command is in flight");

endmodule

>>> hdl/efqc_datapath.sv
// datapath: destination queue cells, car state, match and encode stages, result register
// depends on efqc_pkg; driven by efqc_ctrl commands
module efqc_datapath
   import efqc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic               clock,
   input  logic               reset,
   input  efqc_cmd_type       cmd,
   input  logic [FLOOR_W-1:0] top_floor,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [FLOOR_W-1:0] req_floor,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic               req_alarm_value,
   input  logic               req_door_closed,
   output logic               rsp_accepted,
   output logic [FLOOR_W-1:0] rsp_car_floor,
   output logic [DIR_W-1:0]   rsp_direction,
   output logic               rsp_door_open_request,
   output logic [FLOOR_W-1:0] rsp_queue_count,
   output logic [FLOOR_W-1:0] rsp_head_floor,
   output logic               rsp_found,
   output logic [FLOOR_W-1:0] rsp_slot_floor,
   output logic               rsp_alarm_on
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   // queue cells and car state
   logic [FLOOR_W-1:0] q_ff [QUEUE_DEPTH];
   logic [FLOOR_W-1:0] q_in [QUEUE_DEPTH];
   logic [FLOOR_W-1:0] q_up [QUEUE_DEPTH];
   logic [FLOOR_W-1:0] q_dn [QUEUE_DEPTH];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [FLOOR_W-1:0] car_ff, car_in;
   logic               alarm_ff, alarm_in;
   logic [DIR_W-1:0]   dir_ff, dir_in;

   // latched command
   logic [CMD_W-1:0]   cmd_ff;
   logic [FLOOR_W-1:0] fl_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic               av_ff;
   logic               dc_ff;

   // match and encode stages
   logic [QUEUE_DEPTH-1:0] match_ff, match_in;
   logic [FLOOR_W-1:0]     slot_data_ff, slot_data_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   logic                   any_ff, any_in;

   // result register
   logic               acc_ff, acc_in;
   logic               req_open_ff, req_open_in;
   logic               found_ff, found_in;
   logic [FLOOR_W-1:0] sf_ff, sf_in;

   logic [CMP_W-1:0]   count_x, slot_x, ins_pos, rm_pos;
   logic               do_insert, do_remove, do_clear, ins_ok;
   logic [CNT_W+FLOOR_W-1:0] count_wide;
   logic               tail_clean;

   assign count_x = CMP_W'(count_ff);
   assign slot_x  = CMP_W'(slot_ff);

   always_comb begin
      match_in     = '0;
      slot_data_in = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         match_in[i] = (CMP_W'(i) < count_x) && (q_ff[i] == fl_ff);
         if (CMP_W'(i) == slot_x) begin
            slot_data_in = q_ff[i];
         end
      end
   end

   always_comb begin
      pos_in = '0;
      any_in = |match_ff;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            pos_in = IDX_W'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_up[i] = '0;
         q_dn[i] = '0;
      end
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         q_up[i]   = q_ff[i+1];
         q_dn[i+1] = q_ff[i];
      end
   end

   always_comb begin
      do_insert   = 1'b0;
      do_remove   = 1'b0;
      do_clear    = 1'b0;
      acc_in      = 1'b0;
      req_open_in = 1'b0;
      found_in    = 1'b0;
      sf_in       = '0;
      car_in      = car_ff;
      alarm_in    = alarm_ff;
      dir_in      = dir_ff;
      rm_pos      = CMP_W'(pos_ff);
      ins_ok      = (fl_ff <= top_floor) && (count_x < CMP_W'(QUEUE_DEPTH)) && !any_ff;
      ins_pos     = count_x;
      if (cmd_ff == CMD_INSERT && slot_x < count_x) begin
         ins_pos = slot_x;
      end
      unique case (cmd_ff)
         CMD_TICK: begin
            dir_in = DIR_STOP;
            if (!alarm_ff && count_ff != '0 && dc_ff) begin
               if (car_ff < q_ff[0]) begin
                  car_in = car_ff + 1'b1;
                  dir_in = DIR_UP;
               end else if (car_ff > q_ff[0]) begin
                  car_in = car_ff - 1'b1;
                  dir_in = DIR_DOWN;
               end else begin
                  do_remove   = 1'b1;
                  rm_pos      = '0;
                  req_open_in = 1'b1;
               end
            end
         end
         CMD_APPEND, CMD_INSERT: begin
            do_insert = ins_ok;
            acc_in    = ins_ok;
         end
         CMD_REMOVE: begin
            do_remove = any_ff;
            acc_in    = any_ff;
         end
         CMD_CLEAR:  do_clear = 1'b1;
         CMD_ALARM:  alarm_in = av_ff;
         CMD_SETFL:  car_in   = fl_ff;
         CMD_LOOKUP: found_in = any_ff;
         CMD_RDSLOT: begin
            if (slot_x < count_x) begin
               found_in = 1'b1;
               sf_in    = slot_data_ff;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_in[i] = q_ff[i];
         if (do_clear) begin
            q_in[i] = '0;
         end else if (do_insert) begin
            if (CMP_W'(i) == ins_pos) begin
               q_in[i] = fl_ff;
            end else if (CMP_W'(i) > ins_pos) begin
               q_in[i] = q_dn[i];
            end
         end else if (do_remove) begin
            if (CMP_W'(i) >= rm_pos) begin
               q_in[i] = q_up[i];
            end
         end
      end
      if (do_clear) begin
         count_in = '0;
      end else if (do_insert) begin
         count_in = count_ff + 1'b1;
      end else if (do_remove) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            q_ff[i] <= '0;
         end
         count_ff <= '0;
         car_ff   <= '0;
         alarm_ff <= 1'b0;
         dir_ff   <= DIR_STOP;
      end else if (cmd.apply) begin
         q_ff     <= q_in;
         count_ff <= count_in;
         car_ff   <= car_in;
         alarm_ff <= alarm_in;
         dir_ff   <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_cmd;
         fl_ff   <= req_floor;
         slot_ff <= req_slot;
         av_ff   <= req_alarm_value;
         dc_ff   <= req_door_closed;
      end
      if (cmd.match) begin
         match_ff     <= match_in;
         slot_data_ff <= slot_data_in;
      end
      if (cmd.encode) begin
         pos_ff <= pos_in;
         any_ff <= any_in;
      end
      if (cmd.apply) begin
         acc_ff      <= acc_in;
         req_open_ff <= req_open_in;
         found_ff    <= found_in;
         sf_ff       <= sf_in;
      end
   end

   assign count_wide            = {{FLOOR_W{1'b0}}, count_ff};
   assign rsp_accepted          = acc_ff;
   assign rsp_car_floor         = car_ff;
   assign rsp_direction         = dir_ff;
   assign rsp_door_open_request = req_open_ff;
   assign rsp_queue_count       = count_wide[FLOOR_W-1:0];
   assign rsp_head_floor        = q_ff[0];
   assign rsp_found             = found_ff;
   assign rsp_slot_floor        = sf_ff;
   assign rsp_alarm_on          = alarm_ff;

   always_comb begin
      tail_clean = 1'b1;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (CMP_W'(i) >= count_x && q_ff[i] != '0) begin
            tail_clean = 1'b0;
         end
      end
   end

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_x <= CMP_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_tail_zero: assert property (@(posedge clock) disable iff (reset)
      tail_clean)
      else $error("vacated queue entry not cleared");

   a_arrival_stops: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.apply) && req_open_ff |-> dir_ff == DIR_STOP && !acc_ff)
      else $error("door request with car moving or queue edit");

   a_accept_changes_count: assert property (@(posedge clock) disable iff (reset)
      cmd.apply && acc_in |=> count_ff != $past(count_ff))
      else $error("accepted command left count unchanged");

endmodule

>>> hdl/elevator_floor_queue_controller.sv
// elevator floor queue controller, top level
// depends on efqc_pkg, efqc_csr, efqc_ctrl, efqc_datapath
//
// One command per req_ transfer, one result per rsp_ transfer, in order.
// req_tuser carries the command code; req_tdata the floor, slot, alarm value
// and door status. The result reports the queue edit outcome, the car floor,
// direction, door open request, queue count and head, lookup or slot read
// result and the alarm state after the command.
// A command runs through the match, encode and apply steps over the queue cells before its
// result is registered, and a new command is taken only after the last one is applied.
// If rsp_tready is low the result is held in its register; the next command may still be
// taken and runs up to its apply step, where it waits. top_floor is written through the
// csr_ port; the user must write it only while no command is pending, which the block
// does not enforce. Reset empties the queue, puts the car at floor 0 with the alarm off
// and no direction, and sets top_floor to 20; the block is ready on the next cycle.
module elevator_floor_queue_controller
   import efqc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // floor[5:0], slot[10:6], alarm_value[11], door_closed[12]
   input  logic [3:0]  req_tuser,   // cmd[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // accepted[0], car_floor[6:1], direction[8:7],
                                    // door_open_request[9], queue_count[15:10],
                                    // head_floor[21:16], found[22], slot_floor[28:23],
                                    // alarm_on[29]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   efqc_cmd_type       cmd;
   logic [FLOOR_W-1:0] top_floor;
   logic               accepted;
   logic [FLOOR_W-1:0] car_floor;
   logic [DIR_W-1:0]   direction;
   logic               door_open_request;
   logic [FLOOR_W-1:0] queue_count;
   logic [FLOOR_W-1:0] head_floor;
   logic               found;
   logic [FLOOR_W-1:0] slot_floor;
   logic               alarm_on;

   efqc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .top_floor   (top_floor)
   );

   efqc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   efqc_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .top_floor             (top_floor),
      .req_cmd               (req_tuser[3:0]),
      .req_floor             (req_tdata[5:0]),
      .req_slot              (req_tdata[10:6]),
      .req_alarm_value       (req_tdata[11]),
      .req_door_closed       (req_tdata[12]),
      .rsp_accepted          (accepted),
      .rsp_car_floor         (car_floor),
      .rsp_direction         (direction),
      .rsp_door_open_request (door_open_request),
      .rsp_queue_count       (queue_count),
      .rsp_head_floor        (head_floor),
      .rsp_found             (found),
      .rsp_slot_floor        (slot_floor),
      .rsp_alarm_on          (alarm_on)
   );

   assign rsp_tdata = {2'b00, alarm_on, slot_floor, found, head_floor, queue_count,
                       door_open_request, direction, car_floor, accepted};

endmodule
